// ===== hdl/bole_pkg.sv =====
// Shared types, codes and widths of the bounded ordered list engine.
`default_nettype none

package bole_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ModeW       = 2;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned TotalW      = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_INS_TAIL = 2'd0,
    MODE_INS_HEAD = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_FIND     = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_NOMATCH = 2'd2
  } status_e;

  typedef struct packed {
    status_e           status;
    logic              found;
    logic [TotalW-1:0] entry_total;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/bole_req_if.sv =====
// Request channel: valid/ready handshake carrying mode and value.
`default_nettype none

interface bole_req_if;
  logic                                valid;
  logic                                ready;
  logic        [bole_pkg::ModeW-1:0]   mode;
  logic signed [bole_pkg::ValueW-1:0]  value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

// ===== hdl/bole_rsp_if.sv =====
// Response channel: valid/ready handshake carrying status, found and entry total.
`default_nettype none

interface bole_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [bole_pkg::StatusW-1:0]     status;
  logic                             found;
  logic [bole_pkg::TotalW-1:0]      entry_total;

  modport source (output valid, output status, output found, output entry_total,
                  input ready);
  modport sink   (input valid, input status, input found, input entry_total,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/bole_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bole_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/bole_core.sv =====
// List sequencer: head pointer, entry count, scan and shift walks over the RAM.
`default_nettype none

module bole_core #(
  parameter int unsigned CAPACITY = bole_pkg::DefCapacity,
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CntW = $clog2(CAPACITY + 1),
  localparam int unsigned OffW = CntW + 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // request side
  input  wire logic                              req_valid_i,
  output logic                                   req_ready_o,
  input  wire logic [bole_pkg::ModeW-1:0]        req_mode_i,
  input  wire logic [bole_pkg::ValueW-1:0]       req_value_i,
  // finished result, held until taken
  output logic                                   res_valid_o,
  input  wire logic                              res_take_i,
  output bole_pkg::result_t                      res_o,
  // RAM port
  output logic                                   ram_we_o,
  output logic [IdxW-1:0]                        ram_waddr_o,
  output logic [bole_pkg::ValueW-1:0]            ram_wdata_o,
  output logic [IdxW-1:0]                        ram_raddr_o,
  input  wire logic [bole_pkg::ValueW-1:0]       ram_rdata_i
);

  import bole_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     pos_q, pos_d;
  status_e             status_q, status_d;
  logic                found_q, found_d;
  mode_e               mode_q, mode_d;
  logic [ValueW-1:0]   value_q, value_d;
  logic [OffW-1:0]     rd_off;
  logic [OffW-1:0]     pos_next;
  logic                full;

  // Map a position in list order to a RAM address relative to the head.
  function automatic logic [IdxW-1:0] to_phys(logic [IdxW-1:0] base, logic [OffW-1:0] off);
    logic [OffW-1:0] s;
    s = OffW'(base) + off;
    if (s >= OffW'(CAPACITY)) begin
      s = s - OffW'(CAPACITY);
    end
    return s[IdxW-1:0];
  endfunction

  assign full     = (count_q == CntW'(CAPACITY));
  assign pos_next = OffW'(pos_q) + OffW'(1);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    pos_d       = pos_q;
    status_d    = status_q;
    found_d     = found_q;
    mode_d      = mode_q;
    value_d     = value_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = to_phys(head_q, OffW'(pos_q));
    ram_wdata_o = ram_rdata_i;
    rd_off      = '0;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          mode_d   = mode_e'(req_mode_i);
          value_d  = req_value_i;
          found_d  = 1'b0;
          status_d = STS_OK;
          unique case (mode_e'(req_mode_i))
            MODE_INS_TAIL: begin
              if (full) begin
                status_d = STS_FULL;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = to_phys(head_q, OffW'(count_q));
                ram_wdata_o = req_value_i;
                count_d     = count_q + CntW'(1);
              end
              state_d = ST_DONE;
            end
            MODE_INS_HEAD: begin
              if (full) begin
                status_d = STS_FULL;
              end else begin
                // step the head back by one slot, wrapping
                head_d      = to_phys(head_q, OffW'(CAPACITY - 1));
                ram_we_o    = 1'b1;
                ram_waddr_o = head_d;
                ram_wdata_o = req_value_i;
                count_d     = count_q + CntW'(1);
              end
              state_d = ST_DONE;
            end
            default: begin
              // remove or find: start the walk at the head
              pos_d = '0;
              if (count_q == '0) begin
                status_d = STS_NOMATCH;
                state_d  = ST_DONE;
              end else begin
                state_d = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_SCAN: begin
        // read data holds entry pos_q; prefetch the next one
        rd_off = pos_next;
        if (ram_rdata_i == value_q) begin
          found_d = 1'b1;
          state_d = (mode_q == MODE_REMOVE) ? ST_SHIFT : ST_DONE;
        end else if (pos_next == OffW'(count_q)) begin
          status_d = STS_NOMATCH;
          state_d  = ST_DONE;
        end else begin
          pos_d = pos_next[CntW-1:0];
        end
      end

      ST_SHIFT: begin
        // read data holds entry pos_q + 1; move it down one slot
        rd_off = pos_next + OffW'(1);
        if (pos_next < OffW'(count_q)) begin
          ram_we_o = 1'b1;
          pos_d    = pos_next[CntW-1:0];
        end else begin
          count_d = count_q - CntW'(1);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    ram_raddr_o = to_phys(head_q, rd_off);
  end

  assign res_o.status      = status_q;
  assign res_o.found       = found_q;
  assign res_o.entry_total = TotalW'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    found_q  <= found_d;
    mode_q   <= mode_d;
    value_q  <= value_d;
  end

endmodule

`default_nettype wire

// ===== hdl/bounded_ordered_list_engine_top.sv =====
// Top level of the bounded ordered list engine: sequencer, value RAM, output register.
//
//   channel | dir | handshake     | word
//   --------+-----+---------------+------------------------------------------
//   req_i   | in  | valid / ready | mode (2b), value (32b signed)
//   rsp_o   | out | valid / ready | status (2b), found (1b), entry_total (5b)
//
// One request at a time. A find walks the list one entry per cycle through
// the single RAM read port. A remove walks to the match, then moves each later
// entry down one slot, one RAM read and write per cycle.
// Reset clears the head pointer and the entry count; the RAM is not cleared.
// A result waits in the output register while the next request is taken in.
`default_nettype none

module bounded_ordered_list_engine_top #(
  parameter int unsigned CAPACITY = bole_pkg::DefCapacity
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bole_req_if.sink    req_i,
  bole_rsp_if.source  rsp_o
);

  import bole_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic              res_valid;
  logic              res_take;
  result_t           res;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [ValueW-1:0] ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  logic [ValueW-1:0] ram_rdata;

  logic              out_valid_q, out_valid_d;
  result_t           out_q;

  bole_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_mode_i  (req_i.mode),
    .req_value_i (req_i.value),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // List entries, kept as a ring starting at the head pointer.
  bole_ram #(
    .Width (ValueW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Load the output register whenever it is empty or being drained.
  assign res_take = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_take) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the word until the sink takes it.
  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.found       = out_q.found;
  assign rsp_o.entry_total = out_q.entry_total;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the bounded ordered list engine with random handshake stalls.
module tb_top;
  import bole_pkg::*;

  // The list depth matches the engine's default, so full and empty show up often.
  localparam int unsigned ListDepth     = DefCapacity;
  // Cycles with no word moving on either channel before the run is declared hung.
  // The longest request is a remove on a full list,
  // and an 80% receiver stall only stretches it by a small factor.
  localparam int unsigned StallLimit    = 4000;
  // Settle time after the last result: one worst-case remove and some margin.
  localparam int unsigned DrainCycles   = 2 * ListDepth + 16;
  localparam int unsigned ItemsPerPhase = 650;

  typedef struct {
    mode_e                    mode;
    logic signed [ValueW-1:0] value;
  } request_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bole_req_if req_if ();
  bole_rsp_if rsp_if ();

  bounded_ordered_list_engine_top #(
    .CAPACITY(ListDepth)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #2 clk_i = ~clk_i;

  // Requests waiting to be driven, the predicted list contents and the results
  // still owed by the engine, oldest first.
  request_t                 pending_words[$];
  logic signed [ValueW-1:0] list_model[$];
  result_t                  expected_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned words_queued;
  int unsigned words_taken;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  logic        word_taken = 1'b0;

  // Apply one request to the predicted list and return the result it should give.
  // Search runs from the head, so a remove takes the duplicate nearest the head.
  function automatic result_t predict_request(request_t rq);
    result_t rs;
    int      pos;
    rs.status = STS_OK;
    rs.found  = 1'b0;
    pos       = -1;
    case (rq.mode)
      MODE_INS_TAIL, MODE_INS_HEAD: begin
        if (list_model.size() >= ListDepth) begin
          rs.status = STS_FULL;
        end else if (rq.mode == MODE_INS_TAIL) begin
          list_model.push_back(rq.value);
        end else begin
          list_model.push_front(rq.value);
        end
      end
      default: begin
        foreach (list_model[i]) begin
          if (pos < 0 && list_model[i] == rq.value) pos = i;
        end
        if (pos < 0) begin
          rs.status = STS_NOMATCH;
        end else begin
          rs.found = 1'b1;
          if (rq.mode == MODE_REMOVE) list_model.delete(pos);
        end
      end
    endcase
    rs.entry_total = TotalW'(list_model.size());
    return rs;
  endfunction

  task automatic add_word(mode_e mode, logic signed [ValueW-1:0] value);
    request_t rq;
    rq.mode  = mode;
    rq.value = value;
    pending_words.push_back(rq);
    words_queued++;
  endtask

  // Random traffic in segments of 32 words, each with its own mix: insert-heavy
  // segments fill the list and hit refusals, remove-heavy ones drain it to empty.
  // Most values come from a small pool so removes and finds actually match.
  task automatic add_random_words(int unsigned count);
    logic signed [ValueW-1:0] pool[8];
    int unsigned              ins_pct;
    int unsigned              rem_pct;
    logic signed [ValueW-1:0] v;
    mode_e                    m;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(3))
          0:       begin ins_pct = 85; rem_pct = 50; end
          1:       begin ins_pct = 20; rem_pct = 80; end
          2:       begin ins_pct = 45; rem_pct = 30; end
          default: begin ins_pct = 50; rem_pct = 50; end
        endcase
        pool[0] = '0;
        pool[1] = '1;
        pool[2] = {1'b0, {(ValueW-1){1'b1}}};
        pool[3] = {1'b1, {(ValueW-1){1'b0}}};
        for (int k = 4; k < 8; k++) pool[k] = $urandom;
      end
      if ($urandom_range(99) < ins_pct) begin
        m = $urandom_range(1) ? MODE_INS_HEAD : MODE_INS_TAIL;
      end else begin
        m = ($urandom_range(99) < rem_pct) ? MODE_REMOVE : MODE_FIND;
      end
      v = ($urandom_range(99) < 75) ? pool[$urandom_range(7)] : ValueW'($urandom);
      add_word(m, v);
    end
  endtask

  // Hold until every queued word is taken and every result has come back.
  task automatic wait_drained();
    while (words_taken != words_queued || expected_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Driver: advance to the next word only once the current one was taken,
  // so valid stays up across back-to-back words. Ready is redrawn every cycle.
  always @(negedge clk_i) begin : drive_words
    request_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || word_taken) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_words.pop_front();
        req_if.valid <= 1'b1;
        req_if.mode  <= nxt.mode;
        req_if.value <= nxt.value;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Record each accepted request word and predict its result at the same edge.
  always @(posedge clk_i) begin : take_words
    request_t rq;
    word_taken = rst_ni && req_if.valid && req_if.ready;
    if (word_taken) begin
      rq.mode  = mode_e'(req_if.mode);
      rq.value = req_if.value;
      expected_results.push_back(predict_request(rq));
      words_taken++;
    end
  end

  // Monitor: compare every accepted result word with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d found %0d entry_total %0d",
                 $time, rsp_if.status, rsp_if.found, rsp_if.entry_total);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, rsp_if.status);
          mismatches++;
        end
        if (rsp_if.found !== want.found) begin
          $display("%0t: found expected %0d actual %0d",
                   $time, want.found, rsp_if.found);
          mismatches++;
        end
        if (rsp_if.entry_total !== want.entry_total) begin
          $display("%0t: entry_total expected %0d actual %0d",
                   $time, want.entry_total, rsp_if.entry_total);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: drop the run if no word moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, StallLimit);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_if.valid  = 1'b0;
    req_if.mode   = '0;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 80;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: find and remove on an empty list.
    add_word(MODE_FIND, '0);
    add_word(MODE_REMOVE, '0);
    // Fill to capacity from both ends: extremes first, then a duplicate pair.
    for (int k = 0; k < ListDepth; k++) begin
      case (k)
        0:       add_word(MODE_INS_TAIL, {1'b0, {(ValueW-1){1'b1}}});
        1:       add_word(MODE_INS_HEAD, {1'b1, {(ValueW-1){1'b0}}});
        2:       add_word(MODE_INS_TAIL, '0);
        3:       add_word(MODE_INS_HEAD, '1);
        4:       add_word(MODE_INS_TAIL, 5);
        5:       add_word(MODE_INS_HEAD, 5);
        default: add_word(k[0] ? MODE_INS_HEAD : MODE_INS_TAIL, ValueW'($urandom));
      endcase
    end
    // Inserts into the full list are refused at either end.
    add_word(MODE_INS_TAIL, 7);
    add_word(MODE_INS_HEAD, 7);
    add_word(MODE_FIND, {1'b1, {(ValueW-1){1'b0}}});
    add_word(MODE_FIND, 32'h1234_5678);
    // Remove one of the duplicates; the other must still be found.
    add_word(MODE_REMOVE, 5);
    add_word(MODE_FIND, 5);
    add_word(MODE_REMOVE, 32'h1234_5678);

    add_random_words(ItemsPerPhase);
    wait_drained();

    send_idle_pct = 80;
    recv_idle_pct = 33;
    add_random_words(ItemsPerPhase);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_words(ItemsPerPhase);
    wait_drained();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bole_pkg.sv
hdl/bole_req_if.sv
hdl/bole_rsp_if.sv
hdl/bole_ram.sv
hdl/bole_core.sv
hdl/bounded_ordered_list_engine_top.sv
sim/tb_top.sv
